[rtl/bmhq_pkg.sv]
package bmhq_pkg;

    // queue geometry
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    // request codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // heap memory access from the sift controller
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        value_t wdata;
        addr_t  raddr_a;
        addr_t  raddr_b;
    } mem_req_t;

    // finished result from the sift controller
    typedef struct packed {
        logic       valid;
        value_t     min_value;
        cnt_t       count;
        logic [1:0] status;
    } res_t;

endpackage

[rtl/bmhq_if.sv]
interface bmhq_in_if;
    import bmhq_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] op;
    value_t     value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bmhq_out_if;
    import bmhq_pkg::*;

    logic       valid;
    logic       ready;
    value_t     min_value;
    cnt_t       count;
    logic [1:0] status;

    modport source (output valid, output min_value, output count, output status, input ready);
    modport sink   (input valid, input min_value, input count, input status, output ready);
endinterface

[rtl/bmhq_ram.sv]
module bmhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

[rtl/bmhq_sift.sv]
module bmhq_sift (
    input  logic                clk,
    input  logic                rst_n,
    bmhq_in_if.sink             in_ch,
    output bmhq_pkg::mem_req_t  mem,
    input  bmhq_pkg::value_t    rdata_a,
    input  bmhq_pkg::value_t    rdata_b,
    output bmhq_pkg::res_t      res,
    input  logic                res_take
);
    import bmhq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_DOWN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    addr_t      pos_reg, pos_next;
    value_t     val_reg, val_next;
    cnt_t       cnt_reg, cnt_next;
    logic [1:0] status_reg, status_next;
    value_t     min_reg, min_next;

    addr_t             parent;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [IDX_W-1:0]  cnt_ext;
    logic              pick_right;
    addr_t             pick_addr;
    value_t            pick_val;
    addr_t             child_a;

    // heap index arithmetic around the current hole
    always_comb
    begin
        parent     = addr_t'(pos_reg - addr_t'(1)) >> 1;
        left_idx   = {1'b0, pos_reg, 1'b1};
        right_idx  = left_idx + IDX_W'(1);
        cnt_ext    = IDX_W'(cnt_reg);
        pick_right = (right_idx < cnt_ext) && (rdata_b < rdata_a);
        pick_addr  = pick_right ? addr_t'(right_idx) : addr_t'(left_idx);
        pick_val   = pick_right ? rdata_b : rdata_a;
        child_a    = addr_t'({pick_addr, 1'b1});
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    // request sequencing and sift steps
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        mem.we      = 1'b0;
        mem.waddr   = pos_reg;
        mem.wdata   = val_reg;
        mem.raddr_a = '0;
        mem.raddr_b = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_ch.op)
                        OP_PUSH:
                        begin
                            if (cnt_reg == cnt_t'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                val_next = in_ch.value;
                                pos_next = addr_t'(cnt_reg);
                                cnt_next = cnt_reg + cnt_t'(1);
                                if (cnt_reg == '0)
                                begin
                                    mem.we    = 1'b1;
                                    mem.waddr = '0;
                                    mem.wdata = in_ch.value;
                                end
                                else
                                begin
                                    mem.raddr_a = addr_t'(addr_t'(cnt_reg) - addr_t'(1)) >> 1;
                                    state_next  = S_UP;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - cnt_t'(1);
                                if (cnt_reg != cnt_t'(1))
                                begin
                                    mem.raddr_a = addr_t'(cnt_reg - cnt_t'(1));
                                    state_next  = S_LAST;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // parent value arrives; move it down while the new item is smaller
                mem.we = 1'b1;
                if (val_reg < rdata_a)
                begin
                    mem.wdata = rdata_a;
                    pos_next  = parent;
                    if (parent == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem.raddr_a = addr_t'(parent - addr_t'(1)) >> 1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PUT:
            begin
                mem.we     = 1'b1;
                state_next = S_DONE;
            end
            S_LAST:
            begin
                // last entry becomes the item to sift down from the root
                val_next    = rdata_a;
                pos_next    = '0;
                mem.raddr_a = addr_t'(1);
                mem.raddr_b = addr_t'(2);
                state_next  = S_DOWN;
            end
            S_DOWN:
            begin
                mem.we = 1'b1;
                if ((left_idx < cnt_ext) && (pick_val < val_reg))
                begin
                    mem.wdata   = pick_val;
                    pos_next    = pick_addr;
                    mem.raddr_a = child_a;
                    mem.raddr_b = child_a + addr_t'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow of the root entry
    always_comb
    begin
        min_next = min_reg;
        if (mem.we && (mem.waddr == '0))
        begin
            min_next = mem.wdata;
        end
    end

    always_comb
    begin
        res.valid     = (state_reg == S_DONE);
        res.min_value = (cnt_reg != '0) ? min_reg : '0;
        res.count     = cnt_reg;
        res.status    = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        min_reg <= min_next;
    end
endmodule

[rtl/binary_min_heap_queue_core.sv]
// an empty push, a full push, a pop on empty, clear or pop to empty go straight to the result
// push: climbs the heap level by level, each step a memory read then compare and write
// pop: descends the heap level by level, both children read in parallel
// one item at a time; the next item is taken once the result sits in the output register
// reset: entry count cleared, queue empty; heap memory contents are not cleared
module binary_min_heap_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    bmhq_in_if.sink     in_ch,
    bmhq_out_if.source  out_ch
);
    import bmhq_pkg::*;

    mem_req_t mem;
    value_t   rdata_a;
    value_t   rdata_b;
    res_t     res;
    logic     res_take;

    logic       out_valid_reg;
    value_t     min_value_reg;
    cnt_t       count_reg;
    logic [1:0] status_reg;

    // heap storage
    bmhq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem.we),
        .waddr   (mem.waddr),
        .wdata   (mem.wdata),
        .raddr_a (mem.raddr_a),
        .raddr_b (mem.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // request sequencing and sifting
    bmhq_sift u_sift (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .mem      (mem),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b),
        .res      (res),
        .res_take (res_take)
    );

    // output register
    assign res_take = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            min_value_reg <= res.min_value;
            count_reg     <= res.count;
            status_reg    <= res.status;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.min_value = min_value_reg;
    assign out_ch.count     = count_reg;
    assign out_ch.status    = status_reg;
endmodule

[rtl/bmhq_checker.sv]
module bmhq_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input bmhq_pkg::value_t       min_value,
    input bmhq_pkg::cnt_t         count,
    input logic [1:0]             status
);
    import bmhq_pkg::*;

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(min_value) && $stable(count) && $stable(status))
        else $error("result payload changed while stalled");

    // never more entries than storage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= cnt_t'(CAPACITY))
        else $error("count beyond capacity");

    // an empty queue shows a zero minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (count == '0) |-> min_value == '0)
        else $error("nonzero minimum on empty queue");

    // error status agrees with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != ST_FULL || count == cnt_t'(CAPACITY))
                   && (status != ST_EMPTY || count == '0))
        else $error("status disagrees with count");
endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .min_value (out_ch.min_value),
    .count     (out_ch.count),
    .status    (out_ch.status)
);
